[hdl/oas_pkg.sv]
// Shared types, codes and constants of the obstacle-avoid steering mode machine.
package oas_pkg;

  localparam int unsigned DIST_WIDTH  = 16;
  localparam int unsigned REG_WIDTH   = 16;
  localparam int unsigned TIME_WIDTH  = 32;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CMP_WIDTH   = (DIST_WIDTH > REG_WIDTH) ? DIST_WIDTH : REG_WIDTH;
  // two extra bits: sign plus carry of dist + tolerance
  localparam int unsigned CTR_WIDTH   = CMP_WIDTH + 2;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_ENABLE  = 2'd1,
    REQ_DISABLE = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    MODE_DISABLED   = 3'd0,
    MODE_RESETTING  = 3'd1,
    MODE_SCANNING   = 3'd2,
    MODE_DECIDING   = 3'd3,
    MODE_REQUESTING = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    DRV_NONE       = 3'd0,
    DRV_STOP       = 3'd1,
    DRV_TURN_RIGHT = 3'd2,
    DRV_TURN_LEFT  = 3'd3,
    DRV_BEAR_RIGHT = 3'd4,
    DRV_BEAR_LEFT  = 3'd5,
    DRV_FORWARD    = 3'd6
  } drive_e;

  typedef enum logic [1:0] {
    SPD_UNCHANGED = 2'd0,
    SPD_TURNING   = 2'd1,
    SPD_CLEAR     = 2'd2,
    SPD_WARNING   = 2'd3
  } speed_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE_COLLIDE  = 8'd0,
    CFG_SIDE_WARN     = 8'd1,
    CFG_SIDE_CLEAR    = 8'd2,
    CFG_FRONT_COLLIDE = 8'd3,
    CFG_FRONT_WARN    = 8'd4,
    CFG_CENTER_TOL    = 8'd5,
    CFG_FRONT_MAX_AGE = 8'd6,
    CFG_SIDE_MAX_AGE  = 8'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [REG_WIDTH-1:0] side_collide_limit;
    logic [REG_WIDTH-1:0] side_warn_limit;
    logic [REG_WIDTH-1:0] side_clear_limit;
    logic [REG_WIDTH-1:0] front_collide_limit;
    logic [REG_WIDTH-1:0] front_warn_limit;
    logic [REG_WIDTH-1:0] center_margin;
    logic [REG_WIDTH-1:0] front_max_age;
    logic [REG_WIDTH-1:0] side_max_age;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    side_collide_limit:  16'd10,
    side_warn_limit:     16'd20,
    side_clear_limit:    16'd60,
    front_collide_limit: 16'd20,
    front_warn_limit:    16'd50,
    center_margin:       16'd5,
    front_max_age:       16'd500,
    side_max_age:        16'd1000
  };

endpackage

[hdl/oas_decide.sv]
// Threshold rules that pick drive command and speed class from the three ranges.
module oas_decide (
  input  oas_pkg::cfg_t                     cfg_i,
  input  logic [oas_pkg::DIST_WIDTH-1:0]    front_i,
  input  logic [oas_pkg::DIST_WIDTH-1:0]    left_i,
  input  logic [oas_pkg::DIST_WIDTH-1:0]    right_i,
  output oas_pkg::drive_e                   drive_o,
  output oas_pkg::speed_e                   speed_o
);

  logic [oas_pkg::CMP_WIDTH-1:0] f, l, r;
  logic [oas_pkg::CMP_WIDTH-1:0] side_col, side_warn, side_clear;
  logic [oas_pkg::CMP_WIDTH-1:0] front_col, front_warn;
  logic signed [oas_pkg::CTR_WIDTH-1:0] ls, rs, ts;
  logic centered;

  assign f          = oas_pkg::CMP_WIDTH'(front_i);
  assign l          = oas_pkg::CMP_WIDTH'(left_i);
  assign r          = oas_pkg::CMP_WIDTH'(right_i);
  assign side_col   = oas_pkg::CMP_WIDTH'(cfg_i.side_collide_limit);
  assign side_warn  = oas_pkg::CMP_WIDTH'(cfg_i.side_warn_limit);
  assign side_clear = oas_pkg::CMP_WIDTH'(cfg_i.side_clear_limit);
  assign front_col  = oas_pkg::CMP_WIDTH'(cfg_i.front_collide_limit);
  assign front_warn = oas_pkg::CMP_WIDTH'(cfg_i.front_warn_limit);

  assign ls = signed'({2'b00, l});
  assign rs = signed'({2'b00, r});
  assign ts = signed'(oas_pkg::CTR_WIDTH'(cfg_i.center_margin));

  // strict window around either side, widened so nothing wraps
  assign centered = ((ls - ts) < rs && rs < (ls + ts)) ||
                    ((rs - ts) < ls && ls < (rs + ts));

  always_comb begin
    speed_o = oas_pkg::SPD_UNCHANGED;
    drive_o = oas_pkg::DRV_FORWARD;
    if (f <= front_col) begin
      speed_o = oas_pkg::SPD_TURNING;
      drive_o = (l > r) ? oas_pkg::DRV_TURN_LEFT : oas_pkg::DRV_TURN_RIGHT;
    end else if (l < side_col) begin
      speed_o = oas_pkg::SPD_TURNING;
      drive_o = oas_pkg::DRV_TURN_RIGHT;
    end else if (r < side_col) begin
      speed_o = oas_pkg::SPD_TURNING;
      drive_o = oas_pkg::DRV_TURN_LEFT;
    end else begin
      // front is known to be above the collide limit here
      speed_o = (f > front_warn) ? oas_pkg::SPD_CLEAR : oas_pkg::SPD_WARNING;
      if (l < side_warn) begin
        drive_o = oas_pkg::DRV_BEAR_RIGHT;
      end else if (r < side_warn) begin
        drive_o = oas_pkg::DRV_BEAR_LEFT;
      end else if (centered || l > side_clear || r > side_clear) begin
        drive_o = oas_pkg::DRV_FORWARD;
      end else begin
        drive_o = (l < r) ? oas_pkg::DRV_BEAR_RIGHT : oas_pkg::DRV_BEAR_LEFT;
      end
    end
  end

endmodule

[hdl/obstacle_avoid_steering_fsm_core.sv]
// Top level: autopilot mode machine with input register, decision logic and result register.
// Path from input transfer to result: input register, then result register.
// Throughput: one item per cycle while out_ready_i stays high; the mode register updates as an item
// moves into the result register, so the following item sees the new mode with no bubble.
// Reset: asynchronous active low; mode returns to disabled, config fields to their
// defaults, both pipeline stages empty. Config writes are always ready.
module obstacle_avoid_steering_fsm_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [oas_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [oas_pkg::REG_WIDTH-1:0]     cfg_data_i,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic                              collided_i,
  input  logic                              scan_done_i,
  input  logic                              request_done_i,
  input  logic [oas_pkg::DIST_WIDTH-1:0]    front_distance_i,
  input  logic [oas_pkg::DIST_WIDTH-1:0]    left_distance_i,
  input  logic [oas_pkg::DIST_WIDTH-1:0]    right_distance_i,
  input  logic [oas_pkg::TIME_WIDTH-1:0]    now_time_i,
  input  logic [oas_pkg::TIME_WIDTH-1:0]    front_stamp_i,
  input  logic [oas_pkg::TIME_WIDTH-1:0]    left_stamp_i,
  input  logic [oas_pkg::TIME_WIDTH-1:0]    right_stamp_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        drive_cmd_o,
  output logic [1:0]                        speed_cmd_o,
  output logic                              sensor_reset_o,
  output logic                              scan_start_o,
  output logic                              front_request_o,
  output logic [2:0]                        mode_now_o,
  output logic                              is_enabled_o
);

  // configuration
  oas_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= oas_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      case (oas_pkg::cfg_idx_e'(cfg_index_i))
        oas_pkg::CFG_SIDE_COLLIDE:  cfg_q.side_collide_limit  <= cfg_data_i;
        oas_pkg::CFG_SIDE_WARN:     cfg_q.side_warn_limit     <= cfg_data_i;
        oas_pkg::CFG_SIDE_CLEAR:    cfg_q.side_clear_limit    <= cfg_data_i;
        oas_pkg::CFG_FRONT_COLLIDE: cfg_q.front_collide_limit <= cfg_data_i;
        oas_pkg::CFG_FRONT_WARN:    cfg_q.front_warn_limit    <= cfg_data_i;
        oas_pkg::CFG_CENTER_TOL:    cfg_q.center_margin       <= cfg_data_i;
        oas_pkg::CFG_FRONT_MAX_AGE: cfg_q.front_max_age       <= cfg_data_i;
        oas_pkg::CFG_SIDE_MAX_AGE:  cfg_q.side_max_age        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                              s1_valid_q;
  logic [1:0]                        s1_req_q;
  logic                              s1_bump_q, s1_scan_ok_q, s1_req_ok_q;
  logic [oas_pkg::DIST_WIDTH-1:0]    s1_front_q, s1_left_q, s1_right_q;
  logic [oas_pkg::TIME_WIDTH-1:0]    s1_now_q, s1_fstamp_q, s1_lstamp_q, s1_rstamp_q;
  logic                              in_xfer, s2_load;

  assign s2_load    = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_load;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s2_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_req_q     <= req_type_i;
      s1_bump_q    <= collided_i;
      s1_scan_ok_q <= scan_done_i;
      s1_req_ok_q  <= request_done_i;
      s1_front_q   <= front_distance_i;
      s1_left_q    <= left_distance_i;
      s1_right_q   <= right_distance_i;
      s1_now_q     <= now_time_i;
      s1_fstamp_q  <= front_stamp_i;
      s1_lstamp_q  <= left_stamp_i;
      s1_rstamp_q  <= right_stamp_i;
    end
  end

  // decision logic
  oas_pkg::drive_e dec_drive;
  oas_pkg::speed_e dec_speed;

  oas_decide u_decide (
    .cfg_i   (cfg_q),
    .front_i (s1_front_q),
    .left_i  (s1_left_q),
    .right_i (s1_right_q),
    .drive_o (dec_drive),
    .speed_o (dec_speed)
  );

  logic [oas_pkg::TIME_WIDTH-1:0] front_age, left_age, right_age;
  logic                           stale, trapped;
  logic [oas_pkg::CMP_WIDTH-1:0]  side_col_w;

  // wrapping age, modulo 2^32
  assign front_age = s1_now_q - s1_fstamp_q;
  assign left_age  = s1_now_q - s1_lstamp_q;
  assign right_age = s1_now_q - s1_rstamp_q;
  assign stale = (front_age > oas_pkg::TIME_WIDTH'(cfg_q.front_max_age)) ||
                 (left_age  > oas_pkg::TIME_WIDTH'(cfg_q.side_max_age)) ||
                 (right_age > oas_pkg::TIME_WIDTH'(cfg_q.side_max_age));

  assign side_col_w = oas_pkg::CMP_WIDTH'(cfg_q.side_collide_limit);
  assign trapped = (oas_pkg::CMP_WIDTH'(s1_right_q) <= side_col_w) &&
                   (oas_pkg::CMP_WIDTH'(s1_left_q)  <= side_col_w);

  // mode register and next-state logic
  oas_pkg::mode_e  mode_q, mode_d;
  oas_pkg::drive_e drive_d;
  oas_pkg::speed_e speed_d;
  logic            sreset_d, sscan_d, sreq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= oas_pkg::MODE_DISABLED;
    end else if (s2_load) begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    drive_d  = oas_pkg::DRV_NONE;
    speed_d  = oas_pkg::SPD_UNCHANGED;
    sreset_d = 1'b0;
    sscan_d  = 1'b0;
    sreq_d   = 1'b0;
    case (oas_pkg::req_e'(s1_req_q))
      oas_pkg::REQ_ENABLE:  mode_d = oas_pkg::MODE_RESETTING;
      oas_pkg::REQ_DISABLE: mode_d = oas_pkg::MODE_DISABLED;
      oas_pkg::REQ_TICK: begin
        case (mode_q)
          oas_pkg::MODE_RESETTING: begin
            drive_d  = oas_pkg::DRV_STOP;
            sreset_d = 1'b1;
            mode_d   = oas_pkg::MODE_SCANNING;
          end
          oas_pkg::MODE_SCANNING: begin
            sscan_d = 1'b1;
            if (s1_scan_ok_q) begin
              mode_d = trapped ? oas_pkg::MODE_RESETTING : oas_pkg::MODE_DECIDING;
            end
          end
          oas_pkg::MODE_DECIDING: begin
            if (s1_bump_q || stale) begin
              mode_d = oas_pkg::MODE_RESETTING;
            end else begin
              mode_d  = oas_pkg::MODE_REQUESTING;
              drive_d = dec_drive;
              speed_d = dec_speed;
            end
          end
          oas_pkg::MODE_REQUESTING: begin
            if (s1_bump_q) begin
              mode_d = oas_pkg::MODE_RESETTING;
            end else begin
              sreq_d = 1'b1;
              if (s1_req_ok_q) begin
                mode_d = oas_pkg::MODE_DECIDING;
              end
            end
          end
          default: begin
            // disabled, and unreachable codes served the same way
            if (s1_bump_q) begin
              drive_d = oas_pkg::DRV_STOP;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      drive_cmd_o     <= drive_d;
      speed_cmd_o     <= speed_d;
      sensor_reset_o  <= sreset_d;
      scan_start_o    <= sscan_d;
      front_request_o <= sreq_d;
      mode_now_o      <= mode_d;
      is_enabled_o    <= (mode_d != oas_pkg::MODE_DISABLED);
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_enabled_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_enabled_o == (mode_now_o != oas_pkg::MODE_DISABLED)))
    else $error("is_enabled disagrees with mode_now");

  a_reset_pulse_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sensor_reset_o |->
      (mode_now_o == oas_pkg::MODE_SCANNING) && (drive_cmd_o == oas_pkg::DRV_STOP))
    else $error("sensor reset without stop into scanning");

  a_request_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && front_request_o |->
      (mode_now_o == oas_pkg::MODE_REQUESTING) || (mode_now_o == oas_pkg::MODE_DECIDING))
    else $error("front request outside requesting flow");

  a_speed_only_on_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (speed_cmd_o != oas_pkg::SPD_UNCHANGED) |->
      (mode_now_o == oas_pkg::MODE_REQUESTING))
    else $error("speed class issued without a decision");

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> out_valid_o)
    else $error("item moved from input register but no result shown");

endmodule
